### src/pia_pkg.sv
// Shared widths, types and tuser bit positions for the palette index assign block.
`timescale 1ns / 1ps

package pia_pkg;

  localparam int COLOR_W     = 32;  // packed RGBA8 color
  localparam int INDEX_W     = 8;   // palette_index field
  localparam int COUNT_W     = 9;   // color_count field, holds 0..256
  localparam int IN_TDATA_W  = 32;  // red, green, blue, alpha
  localparam int OUT_TDATA_W = 24;  // palette_index, color_count, zero pad
  localparam int OUT_TUSER_W = 2;   // is_new_color, table_full_miss

  // out_tuser bit positions
  localparam int OUT_NEW_BIT  = 0;
  localparam int OUT_FULL_BIT = 1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    color_t color;
    logic   new_image;
  } pixel_t;

  typedef struct packed {
    count_t color_count;
    index_t palette_index;
    logic   table_full_miss;
    logic   is_new_color;
  } result_t;

endpackage

### src/palette_index_assign_core.sv
// Top level: palette lookup-or-insert of RGBA8 pixels through a parallel color match.
`timescale 1ns / 1ps

// Palette index assign core. Each input word is one RGBA8 pixel; the block
// packs it red high to alpha low and matches it against every stored color
// at once. On a hit the stored index comes back; on a miss the color is
// written at the next free index and returned with is_new_color set. With
// all PALETTE_ENTRIES entries taken, an unseen color returns index 0 with
// table_full_miss set and nothing is stored. new_image on a pixel empties
// the table before that pixel is handled, so it always lands at index 0.
// Rate: one pixel per clock while out_tready is high; each pixel passes the
// input register, then the result register. The single stage between them
// holds the full-width match of all entries, a one-hot-to-index OR tree and
// the table write, so a color added by one pixel is already found by the
// pixel right after it. The table is flip-flops with no reset; entries at or
// above the fill count are never matched, so no clearing pass is needed.
module palette_index_assign_core
  import pia_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256  // table depth, 2..256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                             // [31:24] alpha
  input  logic                   in_tuser,   // [0] new_image
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] palette_index, [16:8] color_count,
                                             // [23:17] zero
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] is_new_color, [1] table_full_miss
);

  localparam int     IDX_W = $clog2(PALETTE_ENTRIES);
  localparam count_t LIMIT = COUNT_W'(PALETTE_ENTRIES);

  // input register
  logic   in_valid_r, in_valid_nxt;
  pixel_t pix_r;

  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  // color table and fill count
  color_t table_r [PALETTE_ENTRIES];
  count_t count_r, count_nxt;

  logic                       fire;
  logic                       out_free;
  count_t                     base_count;
  logic [PALETTE_ENTRIES-1:0] match;
  logic [IDX_W-1:0]           hit_idx;
  logic                       hit;
  logic                       full;
  logic                       do_write;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // match against every filled entry; stored colors are distinct, so at
  // most one bit is set and a plain OR tree yields the index
  assign base_count = pix_r.new_image ? '0 : count_r;

  always_comb begin
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      match[k] = (COUNT_W'(k) < base_count) && (table_r[k] == pix_r.color);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      hit_idx = hit_idx | (match[k] ? IDX_W'(k) : '0);
    end
  end

  assign hit      = |match;
  assign full     = (base_count == LIMIT);
  assign do_write = fire && !hit && !full;

  always_comb begin
    res_nxt   = '0;
    count_nxt = base_count;
    if (hit) begin
      res_nxt.palette_index = INDEX_W'(hit_idx);
    end else if (!full) begin
      res_nxt.palette_index = INDEX_W'(base_count[IDX_W-1:0]);
      res_nxt.is_new_color  = 1'b1;
      count_nxt             = base_count + COUNT_W'(1);
    end else begin
      res_nxt.table_full_miss = 1'b1;
    end
    res_nxt.color_count = count_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r.color     <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
      pix_r.new_image <= in_tuser;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
    if (do_write) begin
      table_r[base_count[IDX_W-1:0]] <= pix_r.color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - COUNT_W - INDEX_W)'(0), res_r.color_count,
                       res_r.palette_index};
  assign out_tuser  = {res_r.table_full_miss, res_r.is_new_color};

endmodule

### src/pia_checker.sv
// Port-level checker for palette_index_assign_core and its bind.
`timescale 1ns / 1ps

module pia_checker
  import pia_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a word is never both a new color and a full-table miss
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[OUT_NEW_BIT] && out_tuser[OUT_FULL_BIT]))
    else $error("new color and table full miss both set");

  // a new color always takes the last filled entry
  a_new_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_NEW_BIT] |->
      (out_tdata[16:8] != 9'd0) &&
      (out_tdata[7:0] == 8'(out_tdata[16:8] - 9'd1)))
    else $error("new color index does not match fill count");

  // a full-table miss returns index 0 with a nonempty table
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_FULL_BIT] |->
      (out_tdata[7:0] == 8'd0) && (out_tdata[16:8] != 9'd0))
    else $error("full table miss with bad index or count");

  // fill count never exceeds the largest table
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:8] <= 9'd256)
    else $error("color count out of range");

endmodule

bind palette_index_assign_core pia_checker u_pia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
